>>> src/qaar_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion axis-angle rotation pipeline.
// Holds the payload and pipeline types, fixed-point widths and the CORDIC arctangent table.
package qaar_pkg;

    localparam int COMP_WIDTH   = 16;
    localparam int ANG_WIDTH    = 16;
    localparam int HANG_W       = 15;
    localparam int QF           = 28;
    localparam int CORDIC_STEPS = 24;
    localparam int XW           = 34;
    localparam int ZW           = 32;
    localparam int LEN_W        = 62;
    localparam int SQRT_STEPS   = 31;
    localparam int RW           = 31;
    localparam int DW           = QF + 1;
    localparam int DIV_STEPS    = DW;
    localparam int QW           = 32;
    localparam int PW           = 64;
    localparam int HW           = PW - QF;
    localparam int KW           = $clog2(2 * COMP_WIDTH);
    localparam int NORM_HALF    = 30;

    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
    localparam logic signed [ANG_WIDTH:0] HALF_TURN     = 17'sd23040;
    localparam logic signed [ANG_WIDTH:0] NEG_HALF_TURN = -17'sd23040;
    localparam logic signed [ANG_WIDTH:0] QUARTER_TURN  = 17'sd11520;
    localparam logic signed [ANG_WIDTH:0] NEG_QUARTER   = -17'sd11520;
    localparam logic signed [ANG_WIDTH:0] FULL_TURN     = 17'sd46080;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] quat_x;
        logic signed [COMP_WIDTH-1:0] quat_y;
        logic signed [COMP_WIDTH-1:0] quat_z;
        logic signed [COMP_WIDTH-1:0] quat_w;
        logic signed [COMP_WIDTH-1:0] axis_x;
        logic signed [COMP_WIDTH-1:0] axis_y;
        logic signed [COMP_WIDTH-1:0] axis_z;
        logic signed [ANG_WIDTH-1:0]  angle_deg;
    } in_t;

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] rot_x;
        logic signed [COMP_WIDTH-1:0] rot_y;
        logic signed [COMP_WIDTH-1:0] rot_z;
        logic signed [COMP_WIDTH-1:0] rot_w;
        logic                         axis_zero;
    } out_t;

    // Everything an item carries down the pipeline; each unit fills in its own fields.
    typedef struct packed {
        in_t                     item;
        logic                    zero;
        logic [2:0]              sgn;
        logic [2:0][RW-1:0]      mag;
        logic [LEN_W-1:0]        len;
        logic signed [HANG_W-1:0] h;
        logic                    neg;
        logic signed [QW-1:0]    sn;
        logic signed [QW-1:0]    cw;
        logic [RW-1:0]           root;
        logic [2:0][DW-1:0]      nq;
        logic [3:0][QW-1:0]      q;
    } pipe_t;

    // Arctangent of 2^-i in units of 2^-23 degree, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_deg(input int step);
        case (step)
            0:  atan_deg = ZW'(377487360);
            1:  atan_deg = ZW'(222843801);
            2:  atan_deg = ZW'(117744544);
            3:  atan_deg = ZW'(59768969);
            4:  atan_deg = ZW'(30000467);
            5:  atan_deg = ZW'(15014858);
            6:  atan_deg = ZW'(7509261);
            7:  atan_deg = ZW'(3754860);
            8:  atan_deg = ZW'(1877459);
            9:  atan_deg = ZW'(938733);
            10: atan_deg = ZW'(469367);
            11: atan_deg = ZW'(234683);
            12: atan_deg = ZW'(117342);
            13: atan_deg = ZW'(58671);
            14: atan_deg = ZW'(29335);
            15: atan_deg = ZW'(14668);
            16: atan_deg = ZW'(7334);
            17: atan_deg = ZW'(3667);
            18: atan_deg = ZW'(1833);
            19: atan_deg = ZW'(917);
            20: atan_deg = ZW'(458);
            21: atan_deg = ZW'(229);
            22: atan_deg = ZW'(115);
            23: atan_deg = ZW'(57);
            default: atan_deg = '0;
        endcase
    endfunction

endpackage

>>> src/qaar_cordic.sv
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC giving sine and cosine of the folded half angle.
// Depends on qaar_pkg; one iteration per stage plus a final sign and rounding stage.
module qaar_cordic import qaar_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  pipe_t in_pipe,
    output logic  out_valid,
    output pipe_t out_pipe
);

    localparam logic signed [XW-1:0] RND2 = XW'(2);

    logic [CORDIC_STEPS-1:0] valid_reg;
    pipe_t                   side_reg [CORDIC_STEPS];
    logic signed [XW-1:0]    x_reg [CORDIC_STEPS];
    logic signed [XW-1:0]    y_reg [CORDIC_STEPS];
    logic signed [ZW-1:0]    z_reg [CORDIC_STEPS];
    logic signed [XW-1:0]    x_next [CORDIC_STEPS];
    logic signed [XW-1:0]    y_next [CORDIC_STEPS];
    logic signed [ZW-1:0]    z_next [CORDIC_STEPS];
    logic                    out_valid_reg;
    pipe_t                   out_pipe_reg;
    pipe_t                   out_pipe_next;

    always_comb begin
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                xi = CORDIC_GAIN;
                yi = '0;
                zi = {{(ZW-HANG_W-16){in_pipe.h[HANG_W-1]}}, in_pipe.h, 16'b0};
            end else begin
                xi = x_reg[i-1];
                yi = y_reg[i-1];
                zi = z_reg[i-1];
            end
            if (!zi[ZW-1]) begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - atan_deg(i);
            end else begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + atan_deg(i);
            end
        end
    end

    always_comb begin
        logic signed [XW-1:0] xf;
        logic signed [XW-1:0] yf;
        logic signed [XW-1:0] xr;
        logic signed [XW-1:0] yr;
        xf = side_reg[CORDIC_STEPS-1].neg ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
        yf = side_reg[CORDIC_STEPS-1].neg ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];
        xr = (xf + RND2) >>> 2;
        yr = (yf + RND2) >>> 2;
        out_pipe_next    = side_reg[CORDIC_STEPS-1];
        out_pipe_next.sn = yr[QW-1:0];
        out_pipe_next.cw = xr[QW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[CORDIC_STEPS-2:0], in_valid};
            out_valid_reg <= valid_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_pipe;
            for (int i = 1; i < CORDIC_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            out_pipe_reg <= out_pipe_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pipe  = out_pipe_reg;

    localparam logic signed [QW-1:0] TRIG_LIM = QW'((64'sd1 <<< QF) + 64'sd64);

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_pipe_reg.sn <= TRIG_LIM) && (out_pipe_reg.sn >= -TRIG_LIM)
                          && (out_pipe_reg.cw <= TRIG_LIM) && (out_pipe_reg.cw >= -TRIG_LIM))
        else $error("CORDIC output beyond unit range");

endmodule

>>> src/qaar_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of the normalised axis length, one result bit per stage.
// Depends on qaar_pkg.
module qaar_isqrt import qaar_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  pipe_t in_pipe,
    output logic  out_valid,
    output pipe_t out_pipe
);

    logic [SQRT_STEPS-1:0] valid_reg;
    pipe_t                 side_reg [SQRT_STEPS];
    logic [LEN_W-1:0]      v_reg [SQRT_STEPS];
    logic [LEN_W-1:0]      r_reg [SQRT_STEPS];
    logic [LEN_W-1:0]      v_next [SQRT_STEPS];
    logic [LEN_W-1:0]      r_next [SQRT_STEPS];

    always_comb begin
        logic [LEN_W-1:0] vi;
        logic [LEN_W-1:0] ri;
        logic [LEN_W-1:0] bitv;
        logic [LEN_W-1:0] trial;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            if (i == 0) begin
                vi = in_pipe.len;
                ri = '0;
            end else begin
                vi = v_reg[i-1];
                ri = r_reg[i-1];
            end
            bitv  = LEN_W'(1) << (2 * (SQRT_STEPS - 1 - i));
            trial = ri + bitv;
            if (vi >= trial) begin
                v_next[i] = vi - trial;
                r_next[i] = (ri >> 1) + bitv;
            end else begin
                v_next[i] = vi;
                r_next[i] = ri >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_pipe;
            for (int i = 1; i < SQRT_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < SQRT_STEPS; i++) begin
                v_reg[i] <= v_next[i];
                r_reg[i] <= r_next[i];
            end
        end
    end

    always_comb begin
        out_pipe      = side_reg[SQRT_STEPS-1];
        out_pipe.root = r_reg[SQRT_STEPS-1][RW-1:0];
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];

    // A normalised non-zero length lies in [2^60, 2^62), so the root always has its top bit set.
    a_root_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_pipe.zero) |-> out_pipe.root[RW-1])
        else $error("square root of normalised length out of range");

endmodule

>>> src/qaar_div.sv
`timescale 1ns / 1ps
// Three-lane restoring divider forming the unit axis components in Q.28, one bit per stage.
// Depends on qaar_pkg.
module qaar_div import qaar_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  pipe_t in_pipe,
    output logic  out_valid,
    output pipe_t out_pipe
);

    logic [DIV_STEPS-1:0] valid_reg;
    pipe_t                side_reg [DIV_STEPS];
    logic [RW-1:0]        rem_reg  [DIV_STEPS][3];
    logic [DW-1:0]        q_reg    [DIV_STEPS][3];
    logic [RW-1:0]        rem_next [DIV_STEPS][3];
    logic [DW-1:0]        q_next   [DIV_STEPS][3];

    always_comb begin
        logic [RW:0]   r2;
        logic [RW:0]   diff;
        logic [RW-1:0] rt;
        logic [DW-1:0] qi;
        logic          ge;
        for (int i = 0; i < DIV_STEPS; i++) begin
            for (int l = 0; l < 3; l++) begin
                if (i == 0) begin
                    // The scaled magnitude never exceeds the root, so the first bit is a compare.
                    r2 = {1'b0, in_pipe.mag[l]};
                    rt = in_pipe.root;
                    qi = '0;
                end else begin
                    r2 = {rem_reg[i-1][l], 1'b0};
                    rt = side_reg[i-1].root;
                    qi = q_reg[i-1][l];
                end
                ge   = (r2 >= {1'b0, rt});
                diff = r2 - {1'b0, rt};
                rem_next[i][l] = ge ? diff[RW-1:0] : r2[RW-1:0];
                q_next[i][l]   = {qi[DW-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_pipe;
            for (int i = 1; i < DIV_STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 0; i < DIV_STEPS; i++) begin
                for (int l = 0; l < 3; l++) begin
                    rem_reg[i][l] <= rem_next[i][l];
                    q_reg[i][l]   <= q_next[i][l];
                end
            end
        end
    end

    always_comb begin
        out_pipe = side_reg[DIV_STEPS-1];
        for (int l = 0; l < 3; l++) begin
            out_pipe.nq[l] = q_reg[DIV_STEPS-1][l];
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];

    localparam logic [DW-1:0] UNIT = DW'(1) << QF;

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_pipe.zero) |->
            (out_pipe.nq[0] <= UNIT) && (out_pipe.nq[1] <= UNIT) && (out_pipe.nq[2] <= UNIT))
        else $error("unit axis component above one");

endmodule

>>> src/qaar_ham.sv
`timescale 1ns / 1ps
// Two-stage Hamilton product: sixteen registered products, then four sums rounded by QF bits.
// Depends on qaar_pkg.
module qaar_ham import qaar_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  pipe_t                in_pipe,
    input  logic signed [QW-1:0] a [4],
    input  logic signed [QW-1:0] b [4],
    output logic                 out_valid,
    output pipe_t                out_pipe,
    output logic signed [HW-1:0] o [4]
);

    localparam logic signed [PW-1:0] RND = PW'(1) <<< (QF - 1);

    logic                 valid1_reg;
    logic                 valid2_reg;
    pipe_t                side1_reg;
    pipe_t                side2_reg;
    logic signed [PW-1:0] prod_reg  [4][4];
    logic signed [PW-1:0] prod_next [4][4];
    logic signed [HW-1:0] o_reg  [4];
    logic signed [HW-1:0] o_next [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                prod_next[i][j] = a[i] * b[j];
            end
        end
    end

    always_comb begin
        logic signed [PW-1:0] s [4];
        logic signed [PW-1:0] t;
        s[0] = prod_reg[3][0] + prod_reg[0][3] + prod_reg[1][2] - prod_reg[2][1];
        s[1] = prod_reg[3][1] + prod_reg[1][3] + prod_reg[2][0] - prod_reg[0][2];
        s[2] = prod_reg[3][2] + prod_reg[2][3] + prod_reg[0][1] - prod_reg[1][0];
        s[3] = prod_reg[3][3] - prod_reg[0][0] - prod_reg[1][1] - prod_reg[2][2];
        for (int i = 0; i < 4; i++) begin
            t = (s[i] + RND) >>> QF;
            o_next[i] = t[HW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= in_pipe;
            side2_reg <= side1_reg;
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    prod_reg[i][j] <= prod_next[i][j];
                end
                o_reg[i] <= o_next[i];
            end
        end
    end

    assign out_valid = valid2_reg;
    assign out_pipe  = side2_reg;
    assign o         = o_reg;

endmodule

>>> src/quaternion_axis_angle_rotate.sv
`timescale 1ns / 1ps
// Top level of the quaternion axis-angle rotation pipeline.
// Depends on qaar_pkg, qaar_cordic, qaar_isqrt, qaar_div and qaar_ham.

// Rotates quaternion p about an arbitrary axis by an angle in degrees, returning q*p*conj(q)
// saturated to signed Q2.14; a zero-length axis returns p unchanged with axis_zero set. The
// block is a single pipeline that takes one transaction every clock cycle unless the output
// stalls, built as a serial chain of units: axis length and angle folding, a 25-stage
// CORDIC, a 31-stage square root, a 29-stage divider, the forming of q, each Hamilton
// product and the output register. When the result side holds off, the whole pipeline
// waits in place.
module quaternion_axis_angle_rotate import qaar_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam logic signed [HW-1:0] SAT_HI = {{(HW-COMP_WIDTH+1){1'b0}}, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [HW-1:0] SAT_LO = {{(HW-COMP_WIDTH+1){1'b1}}, {(COMP_WIDTH-1){1'b0}}};
    localparam logic signed [PW-1:0] RND    = PW'(1) <<< (QF - 1);

    function automatic logic signed [COMP_WIDTH-1:0] sat_comp(input logic signed [HW-1:0] v);
        if (v > SAT_HI) begin
            sat_comp = SAT_HI[COMP_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            sat_comp = SAT_LO[COMP_WIDTH-1:0];
        end else begin
            sat_comp = v[COMP_WIDTH-1:0];
        end
    endfunction

    logic  en;
    logic  s1_valid_reg, s2_valid_reg, qp_valid_reg, qr_valid_reg, m_valid_reg;
    pipe_t s1_reg, s1_next, s2_reg, s2_next, qp_reg, qr_reg, qr_next;
    logic  c_valid, sq_valid, d_valid, h1_valid, h2_valid;
    pipe_t c_pipe, sq_pipe, d_pipe, h1_pipe, h2_pipe;
    logic signed [PW-1:0] prod_reg [3];
    logic signed [PW-1:0] prod_next [3];
    logic signed [QW-1:0] h1_a [4];
    logic signed [QW-1:0] h1_b [4];
    logic signed [QW-1:0] h2_a [4];
    logic signed [QW-1:0] h2_b [4];
    logic signed [HW-1:0] h1_o [4];
    logic signed [HW-1:0] h2_o [4];
    out_t  m_data_reg, m_data_next;

    // A single enable freezes every stage while a finished transaction waits at the output.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Stage 1: axis magnitudes and squared length; half angle folded into plus or minus 90 degrees.
    always_comb begin
        logic signed [COMP_WIDTH-1:0] ax [3];
        logic [COMP_WIDTH-1:0]        mg;
        logic [2*COMP_WIDTH-1:0]      sq;
        logic [2*COMP_WIDTH+1:0]      acc;
        logic signed [ANG_WIDTH:0]    hw;
        ax[0] = s_data.axis_x;
        ax[1] = s_data.axis_y;
        ax[2] = s_data.axis_z;
        s1_next      = '0;
        s1_next.item = s_data;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            s1_next.sgn[i] = ax[i][COMP_WIDTH-1];
            mg = ax[i][COMP_WIDTH-1] ? COMP_WIDTH'(-ax[i]) : COMP_WIDTH'(ax[i]);
            s1_next.mag[i] = RW'(mg);
            sq  = mg * mg;
            acc = acc + (2*COMP_WIDTH+2)'(sq);
        end
        s1_next.len = LEN_W'(acc);
        hw = {s_data.angle_deg[ANG_WIDTH-1], s_data.angle_deg};
        if (hw > HALF_TURN) begin
            hw = hw - FULL_TURN;
        end else if (hw < NEG_HALF_TURN) begin
            hw = hw + FULL_TURN;
        end
        s1_next.neg = 1'b0;
        if (hw > QUARTER_TURN) begin
            hw = hw - HALF_TURN;
            s1_next.neg = 1'b1;
        end else if (hw < NEG_QUARTER) begin
            hw = hw + HALF_TURN;
            s1_next.neg = 1'b1;
        end
        s1_next.h = hw[HANG_W-1:0];
    end

    // Stage 2: even shift that brings the length into [2^60, 2^62); magnitudes take half of it.
    always_comb begin
        logic [KW-1:0] m;
        logic [KW-1:0] kh;
        m = '0;
        for (int b = 0; b < 2 * COMP_WIDTH; b++) begin
            if (s1_reg.len[b]) begin
                m = KW'(b);
            end
        end
        kh = KW'(NORM_HALF) - (m >> 1);
        s2_next      = s1_reg;
        s2_next.zero = (s1_reg.len == '0);
        s2_next.len  = s1_reg.len << {kh, 1'b0};
        for (int i = 0; i < 3; i++) begin
            s2_next.mag[i] = s1_reg.mag[i] << kh;
        end
    end

    qaar_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s2_valid_reg), .in_pipe(s2_reg),
        .out_valid(c_valid), .out_pipe(c_pipe)
    );

    qaar_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c_valid), .in_pipe(c_pipe),
        .out_valid(sq_valid), .out_pipe(sq_pipe)
    );

    qaar_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid), .in_pipe(sq_pipe),
        .out_valid(d_valid), .out_pipe(d_pipe)
    );

    // Vector part of q: signed unit component times the sine.
    always_comb begin
        logic signed [DW:0] ns;
        for (int i = 0; i < 3; i++) begin
            ns = d_pipe.sgn[i] ? -$signed({1'b0, d_pipe.nq[i]}) : $signed({1'b0, d_pipe.nq[i]});
            prod_next[i] = ns * d_pipe.sn;
        end
    end

    always_comb begin
        logic signed [PW-1:0] t;
        qr_next = qp_reg;
        for (int i = 0; i < 3; i++) begin
            t = (prod_reg[i] + RND) >>> QF;
            qr_next.q[i] = t[QW-1:0];
        end
        qr_next.q[3] = qp_reg.cw;
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            h1_a[i] = qr_reg.q[i];
        end
        h1_b[0] = QW'(qr_reg.item.quat_x);
        h1_b[1] = QW'(qr_reg.item.quat_y);
        h1_b[2] = QW'(qr_reg.item.quat_z);
        h1_b[3] = QW'(qr_reg.item.quat_w);
    end

    qaar_ham u_ham_qp (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(qr_valid_reg), .in_pipe(qr_reg), .a(h1_a), .b(h1_b),
        .out_valid(h1_valid), .out_pipe(h1_pipe), .o(h1_o)
    );

    // Second product with the conjugate of q.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            h2_a[i] = h1_o[i][QW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            h2_b[i] = -$signed(h1_pipe.q[i]);
        end
        h2_b[3] = h1_pipe.q[3];
    end

    qaar_ham u_ham_conj (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(h1_valid), .in_pipe(h1_pipe), .a(h2_a), .b(h2_b),
        .out_valid(h2_valid), .out_pipe(h2_pipe), .o(h2_o)
    );

    always_comb begin
        if (h2_pipe.zero) begin
            m_data_next.rot_x = h2_pipe.item.quat_x;
            m_data_next.rot_y = h2_pipe.item.quat_y;
            m_data_next.rot_z = h2_pipe.item.quat_z;
            m_data_next.rot_w = h2_pipe.item.quat_w;
        end else begin
            m_data_next.rot_x = sat_comp(h2_o[0]);
            m_data_next.rot_y = sat_comp(h2_o[1]);
            m_data_next.rot_z = sat_comp(h2_o[2]);
            m_data_next.rot_w = sat_comp(h2_o[3]);
        end
        m_data_next.axis_zero = h2_pipe.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            qp_valid_reg <= 1'b0;
            qr_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            qp_valid_reg <= d_valid;
            qr_valid_reg <= qp_valid_reg;
            m_valid_reg  <= h2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            qp_reg <= d_pipe;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
            qr_reg     <= qr_next;
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for quaternion_axis_angle_rotate: random and directed rotations with a bit-exact
// integer predictor. Depends on qaar_pkg and the RTL of the rotation pipeline.
module tb;
    import qaar_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    in_t  pending_items[$];
    out_t expected_rot[$];
    int   mismatches;
    int   idle_cycles;
    bit   stim_done;
    bit   calm_phase;
    bit   hold_result;
    int   hold_count;
    int   src_gap;
    int   sink_gap;
    bit   in_taken;

    localparam int WATCHDOG = 20000;

    quaternion_axis_angle_rotate u_dut (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q28(longint v);
        return (v + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint clamp_comp(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Hamilton product in x, y, z, w order, rounded back to the scale of p.
    function automatic void hamilton(input longint a[4], input longint b[4], output longint o[4]);
        o[3] = round_q28(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]);
        o[0] = round_q28(a[3]*b[0] + b[3]*a[0] + a[1]*b[2] - a[2]*b[1]);
        o[1] = round_q28(a[3]*b[1] + b[3]*a[1] + a[2]*b[0] - a[0]*b[2]);
        o[2] = round_q28(a[3]*b[2] + b[3]*a[2] + a[0]*b[1] - a[1]*b[0]);
    endfunction

    function automatic out_t rotate_about_axis(in_t it);
        out_t o;
        longint p[4];
        longint ax[3];
        longint q[4];
        longint qc[4];
        longint t[4];
        longint r[4];
        longint unsigned len2;
        longint unsigned root;
        longint unsigned mag;
        longint h;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint sn;
        longint n;
        int k;
        bit flip;
        p[0] = it.quat_x; p[1] = it.quat_y; p[2] = it.quat_z; p[3] = it.quat_w;
        ax[0] = it.axis_x; ax[1] = it.axis_y; ax[2] = it.axis_z;
        len2 = ax[0]*ax[0] + ax[1]*ax[1] + ax[2]*ax[2];
        if (len2 == 0) begin
            o.rot_x = it.quat_x; o.rot_y = it.quat_y;
            o.rot_z = it.quat_z; o.rot_w = it.quat_w;
            o.axis_zero = 1'b1;
            return o;
        end
        k = 0;
        while (len2 < (64'd1 << 60)) begin
            len2 <<= 2;
            k += 2;
        end
        root = int_sqrt(len2);
        // Half angle folding into the CORDIC's convergence range.
        h = it.angle_deg;
        flip = 1'b0;
        if (h > 23040) h -= 46080;
        if (h < -23040) h += 46080;
        if (h > 11520) begin
            h -= 23040; flip = 1'b1;
        end else if (h < -11520) begin
            h += 23040; flip = 1'b1;
        end
        z = h * 65536;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_deg(i);
            end else begin
                nx = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_deg(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        sn = (y + 2) >>> 2;
        q[3] = (x + 2) >>> 2;
        for (int i = 0; i < 3; i++) begin
            mag = ax[i] < 0 ? -ax[i] : ax[i];
            n = longint'(((mag << (k / 2)) << 28) / root);
            if (ax[i] < 0) n = -n;
            q[i] = round_q28(n * sn);
        end
        qc[0] = -q[0]; qc[1] = -q[1]; qc[2] = -q[2]; qc[3] = q[3];
        hamilton(q, p, t);
        hamilton(t, qc, r);
        o.rot_x = 16'(clamp_comp(r[0]));
        o.rot_y = 16'(clamp_comp(r[1]));
        o.rot_z = 16'(clamp_comp(r[2]));
        o.rot_w = 16'(clamp_comp(r[3]));
        o.axis_zero = 1'b0;
        return o;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            3: return 16'($urandom_range(0, 32768)) - 16'd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t rand_item();
        in_t it;
        it.quat_x = rand_comp(); it.quat_y = rand_comp();
        it.quat_z = rand_comp(); it.quat_w = rand_comp();
        it.axis_x = rand_comp(); it.axis_y = rand_comp(); it.axis_z = rand_comp();
        if ($urandom_range(0, 15) == 0) begin
            it.axis_x = '0; it.axis_y = '0; it.axis_z = '0;
        end
        if ($urandom_range(0, 3) == 0) it.angle_deg = 16'($urandom);
        else it.angle_deg = 16'($urandom_range(0, 46080)) - 16'd23040;
        return it;
    endfunction

    function automatic in_t make_item(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                      logic [15:0] pw, logic [15:0] ax, logic [15:0] ay,
                                      logic [15:0] az, logic [15:0] ang);
        in_t it;
        it.quat_x = px; it.quat_y = py; it.quat_z = pz; it.quat_w = pw;
        it.axis_x = ax; it.axis_y = ay; it.axis_z = az; it.angle_deg = ang;
        return it;
    endfunction

    initial begin
        aresetn = 1'b0;
        stim_done = 1'b0;
        calm_phase = 1'b0;
        hold_result = 1'b0;
        // Directed part: zero axis, tiny and extreme axes, angle extremes and wrap.
        pending_items.push_back(make_item(16'h1234, 16'h8000, 16'h7fff, 16'h4000,
                                          16'd0, 16'd0, 16'd0, 16'h1680));
        pending_items.push_back(make_item(16'h4000, 16'd0, 16'd0, 16'h4000,
                                          16'd0, 16'd0, 16'h4000, 16'd5760));
        pending_items.push_back(make_item(16'h4000, 16'd0, 16'd0, 16'd0,
                                          16'd0, 16'd0, 16'd1, 16'd11520));
        pending_items.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                          16'h8000, 16'h8000, 16'h8000, 16'h8000));
        pending_items.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        pending_items.push_back(make_item(16'h7fff, 16'h8000, 16'd0, 16'd0,
                                          16'h7fff, 16'd0, 16'd0, 16'd23040));
        pending_items.push_back(make_item(16'h7fff, 16'h8000, 16'd0, 16'd0,
                                          16'd0, 16'h8000, 16'd0, -16'sd23040));
        pending_items.push_back(make_item(16'h7fff, 16'h7fff, 16'd0, 16'd0,
                                          16'd0, 16'd0, 16'hffff, 16'd11521));
        pending_items.push_back(make_item(16'h7fff, 16'd0, 16'h7fff, 16'd0,
                                          16'd1, 16'd1, 16'd0, -16'sd11521));
        pending_items.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'd0,
                                          16'd1, 16'd0, 16'd0, 16'd0));
        pending_items.push_back(make_item(16'h2000, 16'h7fff, 16'h8000, 16'h7fff,
                                          16'h1000, 16'h2000, 16'h8000, 16'd7000));
        pending_items.push_back(make_item(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                          16'hffff, 16'hffff, 16'hffff, 16'hffff));
        pending_items.push_back(make_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                          16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
        pending_items.push_back(make_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                                          16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
        for (int i = 0; i < 1900; i++) pending_items.push_back(rand_item());
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // Hold the result side off while items keep arriving, so the pipeline backs up.
        wait (pending_items.size() < 1500);
        hold_result = 1'b1;
        wait (pending_items.size() < 1200);
        calm_phase = 1'b1;
        wait (pending_items.size() == 0 && !s_valid);
        stim_done = 1'b1;
    end

    // Sender: random gaps, one pause until none is outstanding. A held transaction is only
    // replaced once the monitor has seen it taken at the previous rising edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            src_gap <= 0;
        end else if (!s_valid || in_taken) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() == 800 && expected_rot.size() != 0) begin
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         (calm_phase || pending_items.size() < 300 ||
                          $urandom_range(0, 9) != 0)) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
                if (pending_items.size() != 0 && !calm_phase && pending_items.size() >= 300)
                    src_gap <= $urandom_range(0, 12);
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
            hold_count <= 0;
        end else if (hold_result && hold_count < 300) begin
            hold_count <= hold_count + 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else if (!calm_phase && pending_items.size() >= 300 &&
                     $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predicts on input transactions, compares on output transactions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            mismatches <= 0;
            idle_cycles <= 0;
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) expected_rot.push_back(rotate_about_axis(s_data));
            if (m_valid && m_ready) begin
                if (expected_rot.size() == 0) begin
                    if (mismatches < 10) $display("Unexpected result %p", m_data);
                    mismatches <= mismatches + 1;
                end else begin
                    out_t e;
                    e = expected_rot.pop_front();
                    if (e !== m_data) begin
                        if (mismatches < 10) $display("Expected %p, got %p", e, m_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_rot.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_rot.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
